>>> rtl/core/fgwr_pkg.sv
// Shared constants and types for the free-group word reducer.
package fgwr_pkg;

   // Letter store geometry
   localparam int WORD_DEPTH = 1024;
   localparam int ADDR_W     = $clog2(WORD_DEPTH);
   localparam int COUNT_W    = ADDR_W + 1;
   localparam int LETTER_W   = 7;
   localparam int INDEX_W    = 10;
   localparam int TRIM_W     = 10;

   // Distance between a letter and its inverse
   localparam logic [LETTER_W:0] INVERSE_GAP = 8'd32;

   // Beat widths
   localparam int REQ_DATA_W = 24;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 32;

   typedef enum logic [1:0] {
      ACT_APPEND = 2'd0,
      ACT_REDUCE = 2'd1,
      ACT_READ   = 2'd2,
      ACT_CLEAR  = 2'd3
   } action_type;

   // True when two letters are each other's inverse
   function automatic logic is_inverse(input logic [LETTER_W-1:0] a,
                                       input logic [LETTER_W-1:0] b);
      logic [LETTER_W:0] a_wide;
      logic [LETTER_W:0] b_wide;
      a_wide = {1'b0, a};
      b_wide = {1'b0, b};
      return ((a_wide + INVERSE_GAP) == b_wide) || ((b_wide + INVERSE_GAP) == a_wide);
   endfunction

endpackage

>>> rtl/core/free_group_word_reducer.sv
// Top level of the free-group word reducer: letter store, control and result register.
//
// The block keeps one freely reduced word of a free group in a circular store of 1024
// letters (one dual-read, single-write synchronous RAM). Each request beat carries an
// action in req_tuser: append a letter, cyclically reduce, read a position, or clear.
// Every request yields exactly one response beat. An append or a read goes through a RAM
// read, an update and the load of the response register; a clear goes straight to the
// load; a cyclic reduce trims one end pair per step before the load, since each pair
// needs a fresh read of both word ends from the RAM. A stalled response register adds
// its wait before the load. The block takes one request at a time; a finished response
// may wait in the output register while the next request is accepted and worked on. No
// clearing pass is needed after reset.
module free_group_word_reducer (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // tdata: letter[6:0], index[16:7], zero fill
   input  logic [fgwr_pkg::REQ_DATA_W-1:0]  req_tdata,
   // tuser: action[1:0]
   input  logic [fgwr_pkg::REQ_USER_W-1:0]  req_tuser,
   // response channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // tdata: word_length[10:0], cancelled[11], overflow[12], pairs_trimmed[22:13],
   //        letter_out[29:23], read_valid[30], zero fill
   output logic [fgwr_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   localparam int AW = fgwr_pkg::ADDR_W;
   localparam int CW = fgwr_pkg::COUNT_W;
   localparam int LW = fgwr_pkg::LETTER_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_APPEND,
      ST_READ,
      ST_TRIM,
      ST_EMIT
   } state_type;

   // Control and working registers
   state_type                     state_ff, state_in;
   logic [AW-1:0]                 head_ff, head_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [LW-1:0]                 letter_ff, letter_in;
   logic [fgwr_pkg::INDEX_W-1:0]  index_ff, index_in;
   logic [fgwr_pkg::TRIM_W-1:0]   trim_ff, trim_in;
   logic                          cancel_ff, cancel_in;
   logic                          ovf_ff, ovf_in;
   logic [LW-1:0]                 rd_letter_ff, rd_letter_in;
   logic                          rd_valid_ff, rd_valid_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [fgwr_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Letter store ports
   logic [LW-1:0] store_mem [fgwr_pkg::WORD_DEPTH];
   logic [AW-1:0] rd_a_addr, rd_b_addr, wr_addr;
   logic          wr_en;
   logic [LW-1:0] rd_a_ff, rd_b_ff;

   // Request fields
   fgwr_pkg::action_type           req_action;
   logic [LW-1:0]                  req_letter;
   logic [fgwr_pkg::INDEX_W-1:0]   req_index;
   logic                           req_beat;
   logic                           rsp_free;
   logic [AW-1:0]                  last_slot;

   assign req_action = fgwr_pkg::action_type'(req_tuser);
   assign req_letter = req_tdata[LW-1:0];
   assign req_index  = req_tdata[LW +: fgwr_pkg::INDEX_W];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign last_slot  = head_ff + count_ff[AW-1:0] - AW'(1);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Letter store: two registered reads, one write
   always_ff @(posedge clock) begin
      rd_a_ff <= store_mem[rd_a_addr];
      rd_b_ff <= store_mem[rd_b_addr];
      if (wr_en) begin
         store_mem[wr_addr] <= letter_ff;
      end
   end

   // Sequence one action and compute next values
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      letter_in    = letter_ff;
      index_in     = index_ff;
      trim_in      = trim_ff;
      cancel_in    = cancel_ff;
      ovf_in       = ovf_ff;
      rd_letter_in = rd_letter_ff;
      rd_valid_in  = rd_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rd_a_addr    = last_slot;
      rd_b_addr    = last_slot;
      wr_en        = 1'b0;
      wr_addr      = head_ff + count_ff[AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               letter_in    = req_letter;
               index_in     = req_index;
               trim_in      = '0;
               cancel_in    = 1'b0;
               ovf_in       = 1'b0;
               rd_letter_in = '0;
               rd_valid_in  = 1'b0;
               unique case (req_action)
                  fgwr_pkg::ACT_APPEND: begin
                     state_in = ST_APPEND;
                  end
                  fgwr_pkg::ACT_REDUCE: begin
                     rd_a_addr = head_ff;
                     state_in  = ST_TRIM;
                  end
                  fgwr_pkg::ACT_READ: begin
                     rd_a_addr = head_ff + req_index[AW-1:0];
                     state_in  = ST_READ;
                  end
                  fgwr_pkg::ACT_CLEAR: begin
                     count_in = '0;
                     head_in  = '0;
                     state_in = ST_EMIT;
                  end
                  default: state_in = ST_EMIT;
               endcase
            end
         end
         ST_APPEND: begin
            // Cancel against the top letter, else push if room
            if (count_ff != '0 && fgwr_pkg::is_inverse(rd_a_ff, letter_ff)) begin
               count_in  = count_ff - CW'(1);
               cancel_in = 1'b1;
            end else if (count_ff == CW'(fgwr_pkg::WORD_DEPTH)) begin
               ovf_in = 1'b1;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
            end
            state_in = ST_EMIT;
         end
         ST_READ: begin
            if (CW'(index_ff) < count_ff) begin
               rd_letter_in = rd_a_ff;
               rd_valid_in  = 1'b1;
            end
            state_in = ST_EMIT;
         end
         ST_TRIM: begin
            // Drop one end pair per cycle and fetch the new ends
            if (count_ff >= CW'(2) && fgwr_pkg::is_inverse(rd_a_ff, rd_b_ff)) begin
               head_in   = head_ff + AW'(1);
               count_in  = count_ff - CW'(2);
               trim_in   = trim_ff + fgwr_pkg::TRIM_W'(1);
               rd_a_addr = head_ff + AW'(1);
               rd_b_addr = last_slot - AW'(1);
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // Load the response once the output register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, rd_valid_ff, rd_letter_ff, trim_ff,
                               ovf_ff, cancel_ff, count_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      letter_ff    <= letter_in;
      index_ff     <= index_in;
      trim_ff      <= trim_in;
      cancel_ff    <= cancel_in;
      ovf_ff       <= ovf_in;
      rd_letter_ff <= rd_letter_in;
      rd_valid_ff  <= rd_valid_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // Word never grows past the store
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(fgwr_pkg::WORD_DEPTH))
      else $error("word length beyond store depth");

   // An append either cancels or overflows, never both
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff[11] && rsp_data_ff[12]))
      else $error("cancel and overflow both set");

   // A response without a valid read carries no letter
   a_read_letter: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff[30]) |-> (rsp_data_ff[29:23] == '0))
      else $error("letter returned without valid read");

   // An accepted request starts work in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> (state_ff != ST_IDLE))
      else $error("accepted request left unserved");

endmodule
